### rtl/core/rmq_pkg.sv
// shared types and codes for the rotation matrix to quaternion block
// no dependencies; used by the response channel interface and the top level
package rmq_pkg;

   typedef logic [1:0] part_type;

   localparam part_type PART_W = 2'd0;
   localparam part_type PART_X = 2'd1;
   localparam part_type PART_Y = 2'd2;
   localparam part_type PART_Z = 2'd3;

endpackage

### rtl/core/rmq_if.sv
// valid/ready channels carrying a matrix in and a quaternion out
// depends on rmq_pkg for the component index type
interface rmq_req_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] r11, r12, r13;
   logic signed [DATA_WIDTH-1:0] r21, r22, r23;
   logic signed [DATA_WIDTH-1:0] r31, r32, r33;

   modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33, input ready);
   modport sink (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33, output ready);
endinterface

interface rmq_rsp_if #(parameter int DATA_WIDTH = 16);
   import rmq_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] qw, qx, qy, qz;
   part_type                     largest_part;

   modport source (output valid, qw, qx, qy, qz, largest_part, input ready);
   modport sink (input valid, qw, qx, qy, qz, largest_part, output ready);
endinterface

### rtl/core/rotation_matrix_to_quaternion.sv
// rotation matrix to quaternion (largest-component method), fully pipelined
// depends on rmq_pkg and the rmq_req_if / rmq_rsp_if channels
//
// usage:
//   req_chan carries the nine Q.FRAC_BITS matrix entries, rsp_chan the
//   quaternion qw..qz (saturated) and largest_part, the index of the
//   component that was derived from the square root.
//   one matrix may be transferred every cycle; one quaternion comes out
//   for each, in order.
//   the stages are, in order: trace/sum, selection, SW square root stages
//   (SW the root width, one digit-by-digit step each), dividend prep, NW
//   restoring divide stages (NW the dividend width, three dividers side by
//   side) and the output register. defaults: SW = 16, NW = 32.
//   the whole pipeline advances together; when rsp is stalled with a
//   result waiting, every stage holds and req_chan.ready drops, so
//   nothing is lost or repeated. bubbles travel as invalid stages.
//   synchronous reset clears all valid bits; payload registers keep
//   whatever they held.
module rotation_matrix_to_quaternion #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic      clock,
   input  logic      reset,
   rmq_req_if.sink   req_chan,
   rmq_rsp_if.source rsp_chan
);
   import rmq_pkg::*;

   localparam int DW  = DATA_WIDTH;
   localparam int FB  = FRAC_BITS;
   localparam int TW  = DW + 2;
   localparam int DDW = DW + 1;
   localparam int RW  = ((TW > FB + 1) ? TW : FB + 1) + 1;
   localparam int RAW = RW - 1;
   localparam int SW  = (RAW + FB + 1) / 2;
   localparam int OPW = 2 * SW;
   localparam int BW  = SW - 1;
   localparam int DNW = SW + 1;
   localparam int NW  = DW + FB + 2;
   localparam int BXW = (BW > DW) ? BW : DW;

   localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

   logic adv;
   logic out_v_ff;

   assign adv            = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // stage 1: trace combinations and off-diagonal sums
   logic                  s1_v_ff;
   logic signed [TW-1:0]  s1_t_ff [0:3];
   logic signed [TW-1:0]  s1_t_in [0:3];
   logic signed [DDW-1:0] s1_d_ff [0:5];
   logic signed [DDW-1:0] s1_d_in [0:5];

   always_comb begin
      s1_t_in[0] = TW'(req_chan.r11) + TW'(req_chan.r22) + TW'(req_chan.r33);
      s1_t_in[1] = TW'(req_chan.r11) - TW'(req_chan.r22) - TW'(req_chan.r33);
      s1_t_in[2] = TW'(req_chan.r22) - TW'(req_chan.r11) - TW'(req_chan.r33);
      s1_t_in[3] = TW'(req_chan.r33) - TW'(req_chan.r11) - TW'(req_chan.r22);
      s1_d_in[0] = DDW'(req_chan.r23) - DDW'(req_chan.r32);
      s1_d_in[1] = DDW'(req_chan.r31) - DDW'(req_chan.r13);
      s1_d_in[2] = DDW'(req_chan.r12) - DDW'(req_chan.r21);
      s1_d_in[3] = DDW'(req_chan.r12) + DDW'(req_chan.r21);
      s1_d_in[4] = DDW'(req_chan.r31) + DDW'(req_chan.r13);
      s1_d_in[5] = DDW'(req_chan.r23) + DDW'(req_chan.r32);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_chan.valid;
      end
      if (adv) begin
         s1_t_ff <= s1_t_in;
         s1_d_ff <= s1_d_in;
      end
   end

   // square root pipeline, entry 0 is fed by the selection stage
   logic                  sq_v_ff    [0:SW];
   logic [OPW-1:0]        sq_op_ff   [0:SW];
   logic [SW+1:0]         sq_rem_ff  [0:SW];
   logic [SW-1:0]         sq_root_ff [0:SW];
   part_type              sq_idx_ff  [0:SW];
   logic signed [DDW-1:0] sq_d_ff    [0:SW][0:2];
   logic [OPW-1:0]        sq_op_in   [0:SW];
   logic [SW+1:0]         sq_rem_in  [0:SW];
   logic [SW-1:0]         sq_root_in [0:SW];
   part_type              sq_idx_in;
   logic signed [DDW-1:0] sq_d_in    [0:2];
   logic [RAW-1:0]        sel_rad;

   // stage 2: pick the largest combination, first one wins on ties
   always_comb begin
      part_type             w01, w23;
      logic signed [TW-1:0] b01, b23, best;
      logic signed [RW-1:0] rad_s;
      w01 = (s1_t_ff[1] > s1_t_ff[0]) ? PART_X : PART_W;
      b01 = (s1_t_ff[1] > s1_t_ff[0]) ? s1_t_ff[1] : s1_t_ff[0];
      w23 = (s1_t_ff[3] > s1_t_ff[2]) ? PART_Z : PART_Y;
      b23 = (s1_t_ff[3] > s1_t_ff[2]) ? s1_t_ff[3] : s1_t_ff[2];
      sq_idx_in = (b23 > b01) ? w23 : w01;
      best      = (b23 > b01) ? b23 : b01;
      rad_s   = RW'(best) + (RW'(1) << FB);
      sel_rad = rad_s[RW-1] ? '0 : rad_s[RAW-1:0];
      unique case (sq_idx_in)
         PART_W: begin
            sq_d_in[0] = s1_d_ff[0]; sq_d_in[1] = s1_d_ff[1]; sq_d_in[2] = s1_d_ff[2];
         end
         PART_X: begin
            sq_d_in[0] = s1_d_ff[0]; sq_d_in[1] = s1_d_ff[3]; sq_d_in[2] = s1_d_ff[4];
         end
         PART_Y: begin
            sq_d_in[0] = s1_d_ff[1]; sq_d_in[1] = s1_d_ff[3]; sq_d_in[2] = s1_d_ff[5];
         end
         default: begin
            sq_d_in[0] = s1_d_ff[2]; sq_d_in[1] = s1_d_ff[4]; sq_d_in[2] = s1_d_ff[5];
         end
      endcase
   end

   // one root digit per stage
   always_comb begin
      logic [SW+1:0] remn, trial;
      sq_op_in[0]   = OPW'({sel_rad, {FB{1'b0}}});
      sq_rem_in[0]  = '0;
      sq_root_in[0] = '0;
      for (int j = 0; j < SW; j++) begin
         remn  = {sq_rem_ff[j][SW-1:0], sq_op_ff[j][OPW-1 -: 2]};
         trial = {sq_root_ff[j], 2'b01};
         sq_op_in[j+1] = {sq_op_ff[j][OPW-3:0], 2'b00};
         if (remn >= trial) begin
            sq_rem_in[j+1]  = remn - trial;
            sq_root_in[j+1] = {sq_root_ff[j][SW-2:0], 1'b1};
         end else begin
            sq_rem_in[j+1]  = remn;
            sq_root_in[j+1] = {sq_root_ff[j][SW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= SW; j++) sq_v_ff[j] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= s1_v_ff;
         for (int j = 1; j <= SW; j++) sq_v_ff[j] <= sq_v_ff[j-1];
      end
      if (adv) begin
         sq_op_ff   <= sq_op_in;
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
         sq_idx_ff[0] <= sq_idx_in;
         sq_d_ff[0]   <= sq_d_in;
         for (int j = 1; j <= SW; j++) begin
            sq_idx_ff[j] <= sq_idx_ff[j-1];
            sq_d_ff[j]   <= sq_d_ff[j-1];
         end
      end
   end

   // divider pipelines, entry 0 holds the prepared dividends
   logic             dv_v_ff   [0:NW];
   logic [BW-1:0]    dv_big_ff [0:NW];
   logic [DNW-1:0]   dv_den_ff [0:NW];
   part_type         dv_idx_ff [0:NW];
   logic [NW-1:0]    dv_num_ff [0:NW][0:2];
   logic [DNW-1:0]   dv_rem_ff [0:NW][0:2];
   logic [NW-1:0]    dv_q_ff   [0:NW][0:2];
   logic             dv_neg_ff [0:NW][0:2];
   logic [NW-1:0]    dv_num_in [0:NW][0:2];
   logic [DNW-1:0]   dv_rem_in [0:NW][0:2];
   logic [NW-1:0]    dv_q_in   [0:NW][0:2];
   logic             dv_neg_in [0:2];
   logic [BW-1:0]    big_in;

   assign big_in = sq_root_ff[SW][SW-1:1];

   always_comb begin
      logic [DDW-1:0] mag;
      logic [DNW:0]   remn;
      // dividend is |d| * 2^FB plus half the divisor for rounding
      for (int k = 0; k < 3; k++) begin
         dv_neg_in[k] = sq_d_ff[SW][k][DDW-1];
         mag = dv_neg_in[k] ? DDW'(-sq_d_ff[SW][k]) : DDW'(sq_d_ff[SW][k]);
         dv_num_in[0][k] = (NW'(mag) << FB) + NW'({big_in, 1'b0});
         dv_rem_in[0][k] = '0;
         dv_q_in[0][k]   = '0;
      end
      // one restoring quotient bit per stage
      for (int j = 0; j < NW; j++) begin
         for (int k = 0; k < 3; k++) begin
            remn = {dv_rem_ff[j][k], dv_num_ff[j][k][NW-1]};
            dv_num_in[j+1][k] = {dv_num_ff[j][k][NW-2:0], 1'b0};
            if (remn >= {1'b0, dv_den_ff[j]}) begin
               dv_rem_in[j+1][k] = DNW'(remn - {1'b0, dv_den_ff[j]});
               dv_q_in[j+1][k]   = {dv_q_ff[j][k][NW-2:0], 1'b1};
            end else begin
               dv_rem_in[j+1][k] = DNW'(remn);
               dv_q_in[j+1][k]   = {dv_q_ff[j][k][NW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= NW; j++) dv_v_ff[j] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[SW];
         for (int j = 1; j <= NW; j++) dv_v_ff[j] <= dv_v_ff[j-1];
      end
      if (adv) begin
         dv_num_ff <= dv_num_in;
         dv_rem_ff <= dv_rem_in;
         dv_q_ff   <= dv_q_in;
         dv_big_ff[0] <= big_in;
         dv_den_ff[0] <= {big_in, 2'b00};
         dv_idx_ff[0] <= sq_idx_ff[SW];
         dv_neg_ff[0] <= dv_neg_in;
         for (int j = 1; j <= NW; j++) begin
            dv_big_ff[j] <= dv_big_ff[j-1];
            dv_den_ff[j] <= dv_den_ff[j-1];
            dv_idx_ff[j] <= dv_idx_ff[j-1];
            dv_neg_ff[j] <= dv_neg_ff[j-1];
         end
      end
   end

   // saturate, apply signs and place the components
   logic [DW-1:0] out_q_ff [0:3];
   logic [DW-1:0] out_q_in [0:3];
   part_type      out_idx_ff;

   always_comb begin
      logic [NW-1:0]  q;
      logic [DW-1:0]  sv [0:2];
      logic [BXW-1:0] bigx;
      logic [DW-1:0]  bigs;
      part_type       idx;
      idx  = dv_idx_ff[NW];
      bigx = BXW'(dv_big_ff[NW]);
      bigs = (bigx > BXW'(SAT_MAX)) ? SAT_MAX : DW'(bigx);
      for (int k = 0; k < 3; k++) begin
         q = dv_q_ff[NW][k];
         if (dv_big_ff[NW] == '0) begin
            sv[k] = '0;
         end else if (!dv_neg_ff[NW][k]) begin
            sv[k] = (|q[NW-1:DW-1]) ? SAT_MAX : q[DW-1:0];
         end else if ((|q[NW-1:DW]) || (q[DW-1] && (|q[DW-2:0]))) begin
            sv[k] = SAT_MIN;
         end else begin
            sv[k] = -q[DW-1:0];
         end
      end
      for (int c = 0; c < 4; c++) begin
         if (2'(c) == idx) begin
            out_q_in[c] = bigs;
         end else if (2'(c) < idx) begin
            out_q_in[c] = sv[c];
         end else begin
            out_q_in[c] = sv[c-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_v_ff[NW];
      end
      if (adv) begin
         out_q_ff   <= out_q_in;
         out_idx_ff <= dv_idx_ff[NW];
      end
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.qw           = out_q_ff[0];
   assign rsp_chan.qx           = out_q_ff[1];
   assign rsp_chan.qy           = out_q_ff[2];
   assign rsp_chan.qz           = out_q_ff[3];
   assign rsp_chan.largest_part = out_idx_ff;

   // the root-derived component is never negative, and zero forces zeros
   logic lead_neg;
   logic lead_zero;
   logic rest_zero;

   always_comb begin
      unique case (out_idx_ff)
         PART_W: begin
            lead_neg  = out_q_ff[0][DW-1];
            lead_zero = (out_q_ff[0] == '0);
            rest_zero = (out_q_ff[1] == '0) && (out_q_ff[2] == '0) && (out_q_ff[3] == '0);
         end
         PART_X: begin
            lead_neg  = out_q_ff[1][DW-1];
            lead_zero = (out_q_ff[1] == '0);
            rest_zero = (out_q_ff[0] == '0) && (out_q_ff[2] == '0) && (out_q_ff[3] == '0);
         end
         PART_Y: begin
            lead_neg  = out_q_ff[2][DW-1];
            lead_zero = (out_q_ff[2] == '0);
            rest_zero = (out_q_ff[0] == '0) && (out_q_ff[1] == '0) && (out_q_ff[3] == '0);
         end
         default: begin
            lead_neg  = out_q_ff[3][DW-1];
            lead_zero = (out_q_ff[3] == '0);
            rest_zero = (out_q_ff[0] == '0) && (out_q_ff[1] == '0) && (out_q_ff[2] == '0);
         end
      endcase
   end

   a_lead_nonneg: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> !lead_neg)
      else $error("largest component is negative");

   a_zero_root: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && lead_zero) |-> rest_zero)
      else $error("nonzero component with zero root");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !out_v_ff)
      else $error("result valid right after reset");

endmodule
